// ===== rtl/fkp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fkp_pkg: shared types, constants and fixed-point helpers
// Widths, CORDIC arctangent table, rounding products and output saturation
// for the forward pose pipeline.
// ----------------------------------------------------------------------------
package fkp_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int IN_W       = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int ROT_W      = 16;
    localparam int POS_W      = 19;
    localparam int FX_W       = 26;
    localparam int CX_W       = 34;
    localparam int NUM_LANE   = 6;
    localparam int NUM_ROT    = 9;
    localparam int NUM_POS    = 3;
    localparam int NUM_LEN    = 5;
    localparam int CORDIC_LAT = ANGLE_BITS + 2;
    localparam int MUL_LAT    = 5;
    localparam int PIPE_LAT   = CORDIC_LAT + MUL_LAT;

    // Trig lanes.
    localparam int L_B  = 0;
    localparam int L_SH = 1;
    localparam int L_EL = 2;
    localparam int L_WR = 3;
    localparam int L_W2 = 4;
    localparam int L_W3 = 5;

    // Link length slots.
    localparam int LEN1 = 0;
    localparam int LEN2 = 1;
    localparam int LEN3 = 2;
    localparam int LEN4 = 3;
    localparam int LEN5 = 4;

    localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_HEIGHT  = 3'd0,
        CFG_UPPER_ARM    = 3'd1,
        CFG_FOREARM      = 3'd2,
        CFG_SHOULDER_OFS = 3'd3,
        CFG_WRIST_OFS    = 3'd4
    } t_cfg_idx;

    typedef logic signed [FX_W-1:0] t_fx;
    typedef logic signed [CX_W-1:0] t_cx;
    typedef logic signed [ROT_W-1:0] t_rot;
    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        t_fx c;
        t_fx s;
    } t_sc;

    // Rounded product at 20 fractional bits, floor after adding one half.
    function automatic t_fx fmul(t_fx a, t_fx b);
        logic signed [2*FX_W-1:0] p;
        p = a * b + 52'sd524288;
        return t_fx'(p >>> 20);
    endfunction

    function automatic t_rot rot_sat(t_fx v);
        t_fx r;
        r = (v + 26'sd32) >>> 6;
        if (r > 26'sd16384) begin
            return 16'sd16384;
        end else if (r < -26'sd16384) begin
            return -16'sd16384;
        end
        return t_rot'(r);
    endfunction

    function automatic t_pos pos_sat(t_fx v);
        t_fx r;
        r = (v + 26'sd8) >>> 4;
        if (r > 26'sd262143) begin
            return 19'sd262143;
        end else if (r < -26'sd262144) begin
            return -19'sd262144;
        end
        return t_pos'(r);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fkp_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fkp_cordic: six-lane pipelined rotation CORDIC
// One iteration per stage; each lane returns cosine and sine at 20 fractional
// bits after range folding into the right half plane.
// ----------------------------------------------------------------------------
module fkp_cordic (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [fkp_pkg::IN_W-1:0]  i_angle [fkp_pkg::NUM_LANE],
    output logic                           o_valid,
    output fkp_pkg::t_sc                   o_trig [fkp_pkg::NUM_LANE]
);

    localparam int NS = fkp_pkg::ANGLE_BITS;
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - fkp_pkg::ANGLE_BITS)) - 32'd1);

    fkp_pkg::t_cx r_x    [fkp_pkg::NUM_LANE][NS+1];
    fkp_pkg::t_cx r_y    [fkp_pkg::NUM_LANE][NS+1];
    fkp_pkg::t_cx r_z    [fkp_pkg::NUM_LANE][NS+1];
    logic         r_flip [fkp_pkg::NUM_LANE][NS+1];
    logic [NS:0]  r_v;
    logic         r_ov;

    // Fold the phase into [-pi/2, pi/2); the flip negates both results later.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < fkp_pkg::NUM_LANE; l++) begin
            logic [31:0] ph;
            ph = {i_angle[l], 16'h0000} & KEEP;
            r_flip[l][0] <= ph[31] ^ ph[30];
            if (ph[31] ^ ph[30]) begin
                ph = ph ^ 32'h8000_0000;
            end
            r_z[l][0] <= {{(fkp_pkg::CX_W-32){ph[31]}}, ph};
            r_x[l][0] <= fkp_pkg::CORDIC_X0;
            r_y[l][0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_iter
        localparam fkp_pkg::t_cx ANG = {{(fkp_pkg::CX_W-32){1'b0}}, fkp_pkg::ATAN[i]};
        always_ff @(posedge i_clk) begin
            for (int l = 0; l < fkp_pkg::NUM_LANE; l++) begin
                if (!r_z[l][i][fkp_pkg::CX_W-1]) begin
                    r_x[l][i+1] <= r_x[l][i] - (r_y[l][i] >>> i);
                    r_y[l][i+1] <= r_y[l][i] + (r_x[l][i] >>> i);
                    r_z[l][i+1] <= r_z[l][i] - ANG;
                end else begin
                    r_x[l][i+1] <= r_x[l][i] + (r_y[l][i] >>> i);
                    r_y[l][i+1] <= r_y[l][i] - (r_x[l][i] >>> i);
                    r_z[l][i+1] <= r_z[l][i] + ANG;
                end
                r_flip[l][i+1] <= r_flip[l][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < fkp_pkg::NUM_LANE; l++) begin
            fkp_pkg::t_cx xr;
            fkp_pkg::t_cx yr;
            xr = (r_x[l][NS] + 34'sd512) >>> 10;
            yr = (r_y[l][NS] + 34'sd512) >>> 10;
            if (r_flip[l][NS]) begin
                xr = -xr;
                yr = -yr;
            end
            o_trig[l].c <= fkp_pkg::t_fx'(xr);
            o_trig[l].s <= fkp_pkg::t_fx'(yr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[NS-1:0], i_valid};
            r_ov <= r_v[NS];
        end
    end

    assign o_valid = r_ov;

endmodule
`default_nettype wire

// ===== rtl/fkp_mult.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fkp_mult: pose product pipeline
// Five stages of rounded products and sums turn the trig values and link
// lengths into nine saturated rotation entries and three positions.
// ----------------------------------------------------------------------------
module fkp_mult (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  fkp_pkg::t_sc                   i_trig [fkp_pkg::NUM_LANE],
    input  wire logic [fkp_pkg::CFG_W-1:0] i_len  [fkp_pkg::NUM_LEN],
    output logic                           o_valid,
    output fkp_pkg::t_rot                  o_rot  [fkp_pkg::NUM_ROT],
    output fkp_pkg::t_pos                  o_pos  [fkp_pkg::NUM_POS]
);

    fkp_pkg::t_fx len [fkp_pkg::NUM_LEN];
    fkp_pkg::t_fx cb, sb, csh, ssh, cel, sel, cwr, swr, cw2, sw2, cw3, sw3;

    always_comb begin
        for (int k = 0; k < fkp_pkg::NUM_LEN; k++) begin
            len[k] = {{(fkp_pkg::FX_W-fkp_pkg::CFG_W-4){1'b0}}, i_len[k], 4'b0000};
        end
    end

    assign cb  = i_trig[fkp_pkg::L_B].c;
    assign sb  = i_trig[fkp_pkg::L_B].s;
    assign csh = i_trig[fkp_pkg::L_SH].c;
    assign ssh = i_trig[fkp_pkg::L_SH].s;
    assign cel = i_trig[fkp_pkg::L_EL].c;
    assign sel = i_trig[fkp_pkg::L_EL].s;
    assign cwr = i_trig[fkp_pkg::L_WR].c;
    assign swr = i_trig[fkp_pkg::L_WR].s;
    assign cw2 = i_trig[fkp_pkg::L_W2].c;
    assign sw2 = i_trig[fkp_pkg::L_W2].s;
    assign cw3 = i_trig[fkp_pkg::L_W3].c;
    assign sw3 = i_trig[fkp_pkg::L_W3].s;

    // Stage 1: first-level products.
    fkp_pkg::t_fx r1_sbsw2, r1_cbcw2, r1_sbcw2, r1_sw2cb, r1_sw3swr, r1_swrcb;
    fkp_pkg::t_fx r1_sbsw3, r1_sbswr, r1_swrcw2, r1_sw3cwr, r1_cw3cwr, r1_sw2swr;
    fkp_pkg::t_fx r1_l2cb, r1_l3cb, r1_l4sb, r1_l5swr, r1_l2sb, r1_l3sb;
    fkp_pkg::t_fx r1_l4cb, r1_l5sb, r1_l2ssh, r1_l3sel, r1_l5cwr, r1_l1;
    fkp_pkg::t_fx r1_cb, r1_swr, r1_cwr, r1_cw2, r1_cw3, r1_csh, r1_cel, r1_sw3;

    always_ff @(posedge i_clk) begin
        r1_sbsw2  <= fkp_pkg::fmul(sb, sw2);
        r1_cbcw2  <= fkp_pkg::fmul(cb, cw2);
        r1_sbcw2  <= fkp_pkg::fmul(sb, cw2);
        r1_sw2cb  <= fkp_pkg::fmul(sw2, cb);
        r1_sw3swr <= fkp_pkg::fmul(sw3, swr);
        r1_swrcb  <= fkp_pkg::fmul(swr, cb);
        r1_sbsw3  <= fkp_pkg::fmul(sb, sw3);
        r1_sbswr  <= fkp_pkg::fmul(sb, swr);
        r1_swrcw2 <= fkp_pkg::fmul(swr, cw2);
        r1_sw3cwr <= fkp_pkg::fmul(sw3, cwr);
        r1_cw3cwr <= fkp_pkg::fmul(cw3, cwr);
        r1_sw2swr <= fkp_pkg::fmul(sw2, swr);
        r1_l2cb   <= fkp_pkg::fmul(len[fkp_pkg::LEN2], cb);
        r1_l3cb   <= fkp_pkg::fmul(len[fkp_pkg::LEN3], cb);
        r1_l4sb   <= fkp_pkg::fmul(len[fkp_pkg::LEN4], sb);
        r1_l5swr  <= fkp_pkg::fmul(len[fkp_pkg::LEN5], swr);
        r1_l2sb   <= fkp_pkg::fmul(len[fkp_pkg::LEN2], sb);
        r1_l3sb   <= fkp_pkg::fmul(len[fkp_pkg::LEN3], sb);
        r1_l4cb   <= fkp_pkg::fmul(len[fkp_pkg::LEN4], cb);
        r1_l5sb   <= fkp_pkg::fmul(len[fkp_pkg::LEN5], sb);
        r1_l2ssh  <= fkp_pkg::fmul(len[fkp_pkg::LEN2], ssh);
        r1_l3sel  <= fkp_pkg::fmul(len[fkp_pkg::LEN3], sel);
        r1_l5cwr  <= fkp_pkg::fmul(len[fkp_pkg::LEN5], cwr);
        r1_l1     <= len[fkp_pkg::LEN1];
        r1_cb  <= cb;
        r1_swr <= swr;
        r1_cwr <= cwr;
        r1_cw2 <= cw2;
        r1_cw3 <= cw3;
        r1_csh <= csh;
        r1_cel <= cel;
        r1_sw3 <= sw3;
    end

    // Stage 2: third factor of the triple products.
    fkp_pkg::t_fx r2_a, r2_b, r2_c, r2_d, r2_e, r2_g, r2_h, r2_k, r2_m, r2_n;
    fkp_pkg::t_fx r2_x1, r2_x2, r2_x3, r2_y1, r2_y2, r2_y3;
    fkp_pkg::t_fx r2_sbsw2, r2_sbcw2, r2_cbcw2, r2_sw2cb, r2_sw3cwr, r2_cw3cwr;
    fkp_pkg::t_fx r2_sw2swr, r2_l4sb, r2_l4cb, r2_l2ssh, r2_l3sel, r2_l5cwr, r2_l1;
    fkp_pkg::t_fx r2_cw3, r2_sw3;

    always_ff @(posedge i_clk) begin
        r2_a  <= fkp_pkg::fmul(r1_cbcw2, r1_cwr);
        r2_b  <= fkp_pkg::fmul(r1_sbcw2, r1_cwr);
        r2_c  <= fkp_pkg::fmul(r1_sw3swr, r1_cb);
        r2_d  <= fkp_pkg::fmul(r1_swrcb, r1_cw3);
        r2_e  <= fkp_pkg::fmul(r1_sw2cb, r1_cwr);
        r2_g  <= fkp_pkg::fmul(r1_sbsw3, r1_swr);
        r2_h  <= fkp_pkg::fmul(r1_sbswr, r1_cw3);
        r2_k  <= fkp_pkg::fmul(r1_sbsw2, r1_cwr);
        r2_m  <= fkp_pkg::fmul(r1_swrcw2, r1_cw3);
        r2_n  <= fkp_pkg::fmul(r1_sw3swr, r1_cw2);
        r2_x1 <= fkp_pkg::fmul(r1_l2cb, r1_csh);
        r2_x2 <= fkp_pkg::fmul(r1_l3cb, r1_cel);
        r2_x3 <= fkp_pkg::fmul(r1_l5swr, r1_cb);
        r2_y1 <= fkp_pkg::fmul(r1_l2sb, r1_csh);
        r2_y2 <= fkp_pkg::fmul(r1_l3sb, r1_cel);
        r2_y3 <= fkp_pkg::fmul(r1_l5sb, r1_swr);
        r2_sbsw2  <= r1_sbsw2;
        r2_sbcw2  <= r1_sbcw2;
        r2_cbcw2  <= r1_cbcw2;
        r2_sw2cb  <= r1_sw2cb;
        r2_sw3cwr <= r1_sw3cwr;
        r2_cw3cwr <= r1_cw3cwr;
        r2_sw2swr <= r1_sw2swr;
        r2_l4sb   <= r1_l4sb;
        r2_l4cb   <= r1_l4cb;
        r2_l2ssh  <= r1_l2ssh;
        r2_l3sel  <= r1_l3sel;
        r2_l5cwr  <= r1_l5cwr;
        r2_l1     <= r1_l1;
        r2_cw3    <= r1_cw3;
        r2_sw3    <= r1_sw3;
    end

    // Stage 3: sums.
    fkp_pkg::t_fx r3_t, r3_u, r3_r2, r3_r5, r3_r6, r3_r7, r3_r8;
    fkp_pkg::t_fx r3_px, r3_py, r3_pz, r3_c, r3_d, r3_g, r3_h, r3_cw3, r3_sw3;

    always_ff @(posedge i_clk) begin
        r3_t   <= r2_sbsw2 + r2_a;
        r3_u   <= r2_sw2cb - r2_b;
        r3_r2  <= r2_e - r2_sbcw2;
        r3_r5  <= r2_k + r2_cbcw2;
        r3_r6  <= r2_sw3cwr + r2_m;
        r3_r7  <= r2_cw3cwr - r2_n;
        r3_r8  <= -r2_sw2swr;
        r3_px  <= r2_x1 + r2_x2 - r2_l4sb - r2_x3;
        r3_py  <= r2_y1 + r2_y2 + r2_l4cb - r2_y3;
        r3_pz  <= r2_l1 - r2_l2ssh - r2_l3sel - r2_l5cwr;
        r3_c   <= r2_c;
        r3_d   <= r2_d;
        r3_g   <= r2_g;
        r3_h   <= r2_h;
        r3_cw3 <= r2_cw3;
        r3_sw3 <= r2_sw3;
    end

    // Stage 4: the wrist-three turn of the t and u terms.
    fkp_pkg::t_fx r4_tc, r4_ts, r4_uc, r4_us, r4_c, r4_d, r4_g, r4_h;
    fkp_pkg::t_fx r4_r2, r4_r5, r4_r6, r4_r7, r4_r8, r4_px, r4_py, r4_pz;

    always_ff @(posedge i_clk) begin
        r4_tc <= fkp_pkg::fmul(r3_t, r3_cw3);
        r4_ts <= fkp_pkg::fmul(r3_t, r3_sw3);
        r4_uc <= fkp_pkg::fmul(r3_u, r3_cw3);
        r4_us <= fkp_pkg::fmul(r3_u, r3_sw3);
        r4_c  <= r3_c;
        r4_d  <= r3_d;
        r4_g  <= r3_g;
        r4_h  <= r3_h;
        r4_r2 <= r3_r2;
        r4_r5 <= r3_r5;
        r4_r6 <= r3_r6;
        r4_r7 <= r3_r7;
        r4_r8 <= r3_r8;
        r4_px <= r3_px;
        r4_py <= r3_py;
        r4_pz <= r3_pz;
    end

    // Stage 5: final sums, rounding and saturation into the output registers.
    always_ff @(posedge i_clk) begin
        o_rot[0] <= fkp_pkg::rot_sat(r4_c - r4_tc);
        o_rot[1] <= fkp_pkg::rot_sat(r4_ts + r4_d);
        o_rot[2] <= fkp_pkg::rot_sat(r4_r2);
        o_rot[3] <= fkp_pkg::rot_sat(r4_uc + r4_g);
        o_rot[4] <= fkp_pkg::rot_sat(r4_h - r4_us);
        o_rot[5] <= fkp_pkg::rot_sat(r4_r5);
        o_rot[6] <= fkp_pkg::rot_sat(r4_r6);
        o_rot[7] <= fkp_pkg::rot_sat(r4_r7);
        o_rot[8] <= fkp_pkg::rot_sat(r4_r8);
        o_pos[0] <= fkp_pkg::pos_sat(r4_px);
        o_pos[1] <= fkp_pkg::pos_sat(r4_py);
        o_pos[2] <= fkp_pkg::pos_sat(r4_pz);
    end

    logic [fkp_pkg::MUL_LAT-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[fkp_pkg::MUL_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_v[fkp_pkg::MUL_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/six_axis_arm_forward_pose.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// six_axis_arm_forward_pose: forward pose of a six-axis arm
// Joint angles in, base-to-wrist rotation and position out, fully pipelined.
// ----------------------------------------------------------------------------
// How to use this block:
// A joint vector is one beat on the command channel. It is taken at a rising
// edge where start is high and busy is low. busy is always low, so a new
// beat may be issued in every cycle, and one pose leaves per cycle.
// Each pose appears on the o_rot_* and o_pos_* ports for exactly one cycle
// with o_done high, after its command beat has passed through the pipeline:
// the CORDIC, one iteration per stage, followed by five stages of products
// and sums.
// The receiver cannot stall, so results are never held back.
// Link lengths are written through the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data). o_cfg_ready is always high; writes
// to an index past the register list are dropped. Writes should be made
// only while no pose is in flight.
// Reset is synchronous and active low. It empties the pipeline, so no result
// strobes in the cycle after reset, and it restores the default lengths.
// ----------------------------------------------------------------------------
module six_axis_arm_forward_pose (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [15:0]            i_angle_base,
    input  wire logic signed [15:0]            i_angle_shoulder,
    input  wire logic signed [15:0]            i_angle_elbow,
    input  wire logic signed [15:0]            i_angle_wrist_one,
    input  wire logic signed [15:0]            i_angle_wrist_two,
    input  wire logic signed [15:0]            i_angle_wrist_three,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fkp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fkp_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_done,
    output logic signed [15:0]                 o_rot_0_0,
    output logic signed [15:0]                 o_rot_0_1,
    output logic signed [15:0]                 o_rot_0_2,
    output logic signed [15:0]                 o_rot_1_0,
    output logic signed [15:0]                 o_rot_1_1,
    output logic signed [15:0]                 o_rot_1_2,
    output logic signed [15:0]                 o_rot_2_0,
    output logic signed [15:0]                 o_rot_2_1,
    output logic signed [15:0]                 o_rot_2_2,
    output logic signed [18:0]                 o_pos_x,
    output logic signed [18:0]                 o_pos_y,
    output logic signed [18:0]                 o_pos_z
);

    // Link length registers, Q0.16 metres.
    logic [fkp_pkg::CFG_W-1:0] r_len [fkp_pkg::NUM_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[fkp_pkg::LEN1] <= 16'd8343;
            r_len[fkp_pkg::LEN2] <= 16'd40108;
            r_len[fkp_pkg::LEN3] <= 16'd37506;
            r_len[fkp_pkg::LEN4] <= 16'd10741;
            r_len[fkp_pkg::LEN5] <= 16'd7583;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (fkp_pkg::t_cfg_idx'(i_cfg_index))
                fkp_pkg::CFG_BASE_HEIGHT:  r_len[fkp_pkg::LEN1] <= i_cfg_data;
                fkp_pkg::CFG_UPPER_ARM:    r_len[fkp_pkg::LEN2] <= i_cfg_data;
                fkp_pkg::CFG_FOREARM:      r_len[fkp_pkg::LEN3] <= i_cfg_data;
                fkp_pkg::CFG_SHOULDER_OFS: r_len[fkp_pkg::LEN4] <= i_cfg_data;
                fkp_pkg::CFG_WRIST_OFS:    r_len[fkp_pkg::LEN5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // The two partial angle sums wrap modulo a full turn, which is exact for
    // binary angles.
    logic [fkp_pkg::IN_W-1:0] angle [fkp_pkg::NUM_LANE];
    logic [fkp_pkg::IN_W-1:0] sum_el;

    assign sum_el = i_angle_shoulder + i_angle_elbow;

    assign angle[fkp_pkg::L_B]  = i_angle_base;
    assign angle[fkp_pkg::L_SH] = i_angle_shoulder;
    assign angle[fkp_pkg::L_EL] = sum_el;
    assign angle[fkp_pkg::L_WR] = sum_el + i_angle_wrist_one;
    assign angle[fkp_pkg::L_W2] = i_angle_wrist_two;
    assign angle[fkp_pkg::L_W3] = i_angle_wrist_three;

    logic         trig_valid;
    fkp_pkg::t_sc trig [fkp_pkg::NUM_LANE];

    fkp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_angle (angle),
        .o_valid (trig_valid),
        .o_trig  (trig)
    );

    fkp_pkg::t_rot rot [fkp_pkg::NUM_ROT];
    fkp_pkg::t_pos pos [fkp_pkg::NUM_POS];

    fkp_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (trig_valid),
        .i_trig  (trig),
        .i_len   (r_len),
        .o_valid (o_done),
        .o_rot   (rot),
        .o_pos   (pos)
    );

    assign o_rot_0_0 = rot[0];
    assign o_rot_0_1 = rot[1];
    assign o_rot_0_2 = rot[2];
    assign o_rot_1_0 = rot[3];
    assign o_rot_1_1 = rot[4];
    assign o_rot_1_2 = rot[5];
    assign o_rot_2_0 = rot[6];
    assign o_rot_2_1 = rot[7];
    assign o_rot_2_2 = rot[8];
    assign o_pos_x   = pos[0];
    assign o_pos_y   = pos[1];
    assign o_pos_z   = pos[2];

`ifndef SYNTHESIS
    // Every result strobe goes back to an earlier command beat.
    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, fkp_pkg::PIPE_LAT))
        else $error("result strobe without a command beat");

    // Reset empties the pipeline.
    a_no_done_after_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

    // Saturation keeps a rotation entry within one.
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rot_2_2 <= 16'sd16384 && o_rot_2_2 >= -16'sd16384
                    && o_rot_0_0 <= 16'sd16384 && o_rot_0_0 >= -16'sd16384))
        else $error("rotation entry out of range");
`endif

endmodule
`default_nettype wire
